>>> hdl/tfls_pkg.sv
// Shared types and constants for the telemetry frame log summarizer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package tfls_pkg;

  // Frame window limit and field widths.
  localparam int FRAME_CAP   = 1024;
  localparam int COUNT_W     = 11;
  localparam int TS_W        = 48;
  localparam int SEQ_W       = 32;
  localparam int VOLT_W      = 17;
  localparam int MV_W        = 16;
  localparam int CURR_W      = 17;
  localparam int TEMP_W      = 12;
  localparam int TOTAL_W     = 22;
  localparam int GPS_W       = 8;
  localparam int SATS_W      = 8;
  localparam int STATUS_W    = 4;
  localparam int RATE_W      = 30;

  // Serial divider: quotient bits, and the scale that turns frames per ms into mHz.
  localparam int DIV_W       = 30;
  localparam int RATE_SCALE  = 1000000;

  // Queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 4;

  // Register reset values.
  localparam int LOW_VOLTAGE_RST = 22000;
  localparam int TEMP_MIN_RST    = -400;
  localparam int TEMP_MAX_RST    = 1200;
  localparam int FRAME_LIMIT_RST = 1024;

  typedef enum logic [1:0] {
    REG_LOW_VOLTAGE,
    REG_TEMP_MIN,
    REG_TEMP_MAX,
    REG_FRAME_LIMIT
  } reg_index_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_VOLTAGE,
    ST_CURRENT,
    ST_TEMP,
    ST_GPS,
    ST_SATS,
    ST_SEQUENCE,
    ST_TIMESTAMP,
    ST_NO_ELAPSED
  } status_t;

  typedef struct packed {
    logic [MV_W-1:0]           low_voltage_mv;
    logic signed [TEMP_W-1:0]  temp_min_tenths;
    logic signed [TEMP_W-1:0]  temp_max_tenths;
    logic [COUNT_W-1:0]        frame_limit;
  } cfg_t;

  // One result to produce: an error or empty status, or a summary to finish.
  typedef struct packed {
    status_t                    status;
    logic [COUNT_W-1:0]         frames;
    logic [MV_W-1:0]            vmin;
    logic [MV_W-1:0]            vmax;
    logic signed [TOTAL_W-1:0]  total;
    logic [COUNT_W-1:0]         low_count;
    logic [TS_W-1:0]            elapsed;
  } job_t;

endpackage

`default_nettype wire

>>> hdl/tfls_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on tfls_pkg for its widths.
`default_nettype none

module tfls_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [tfls_pkg::DIV_W-1:0]  dividend,
  input  wire logic [tfls_pkg::TS_W-1:0]   divisor,
  output logic                             done,
  output logic [tfls_pkg::DIV_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(tfls_pkg::DIV_W);

  logic [tfls_pkg::TS_W-1:0]   rem_r, rem_nxt;
  logic [tfls_pkg::TS_W-1:0]   dsr_r;
  logic [tfls_pkg::DIV_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [tfls_pkg::TS_W:0]     rem_sh;
  logic [tfls_pkg::TS_W:0]     rem_sub;

  // One step: shift in the next dividend bit and subtract the divisor if it fits.
  always_comb begin
    rem_sh  = {rem_r, quo_r[tfls_pkg::DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    if (!rem_sub[tfls_pkg::TS_W]) begin
      rem_nxt = rem_sub[tfls_pkg::TS_W-1:0];
      quo_nxt = {quo_r[tfls_pkg::DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[tfls_pkg::TS_W-1:0];
      quo_nxt = {quo_r[tfls_pkg::DIV_W-2:0], 1'b0};
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(tfls_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient register starts out holding the dividend.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> hdl/tfls_queue.sv
// Short job queue between the frame checker and the result builder.
// Depends on tfls_pkg for the job type and depth.
`default_nettype none

module tfls_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire tfls_pkg::job_t  push_job,
  output logic                 full,
  input  wire logic            pop,
  output tfls_pkg::job_t       pop_job,
  output logic                 empty
);

  localparam int PTR_W = (tfls_pkg::QUEUE_DEPTH > 1) ? $clog2(tfls_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(tfls_pkg::QUEUE_DEPTH + 1);

  tfls_pkg::job_t      slot_r [tfls_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]    count_r;

  assign full    = (count_r == CNT_W'(tfls_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = slot_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(tfls_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(tfls_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tfls_front.sv
// Frame checker: validates each frame, keeps the running log statistics and
// queues a job for every result. Depends on tfls_pkg.
`default_nettype none

module tfls_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire tfls_pkg::cfg_t                     cfg,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [tfls_pkg::TS_W-1:0]          in_timestamp_ms,
  input  wire logic signed [tfls_pkg::SEQ_W-1:0]  in_sequence_number,
  input  wire logic signed [tfls_pkg::VOLT_W-1:0] in_voltage_mv,
  input  wire logic signed [tfls_pkg::CURR_W-1:0] in_current_ma,
  input  wire logic signed [tfls_pkg::TEMP_W-1:0] in_temperature_tenths,
  input  wire logic [tfls_pkg::GPS_W-1:0]         in_gps_fix,
  input  wire logic signed [tfls_pkg::SATS_W-1:0] in_satellites,
  input  wire logic                               in_last_frame,
  input  wire logic                               q_full,
  output logic                                    push,
  output tfls_pkg::job_t                          job
);

  localparam int CW = tfls_pkg::COUNT_W;

  logic [CW-1:0]                        frame_counter_r, frame_counter_nxt;
  logic [tfls_pkg::TS_W-1:0]            first_time_r, first_time_nxt;
  logic [tfls_pkg::TS_W-1:0]            previous_time_r, previous_time_nxt;
  logic [tfls_pkg::SEQ_W-1:0]           previous_sequence_r, previous_sequence_nxt;
  logic [tfls_pkg::MV_W-1:0]            min_voltage_r, min_voltage_nxt;
  logic [tfls_pkg::MV_W-1:0]            max_voltage_r, max_voltage_nxt;
  logic signed [tfls_pkg::TOTAL_W-1:0]  temperature_total_r, temperature_total_nxt;
  logic [CW-1:0]                        low_counter_r, low_counter_nxt;
  logic                                 error_seen_r, error_seen_nxt;

  logic                                 accept;
  logic [CW-1:0]                        limit;
  logic                                 in_window;
  logic [tfls_pkg::SEQ_W-1:0]           seq_expect;
  logic [tfls_pkg::MV_W-1:0]            volt_u;
  tfls_pkg::status_t                    status;

  // Values after this frame is summarized.
  logic [CW-1:0]                        upd_counter;
  logic [tfls_pkg::TS_W-1:0]            upd_first;
  logic [tfls_pkg::TS_W-1:0]            upd_prev;
  logic [tfls_pkg::SEQ_W-1:0]           upd_seq;
  logic [tfls_pkg::MV_W-1:0]            upd_min;
  logic [tfls_pkg::MV_W-1:0]            upd_max;
  logic signed [tfls_pkg::TOTAL_W-1:0]  upd_total;
  logic [CW-1:0]                        upd_low;
  logic [tfls_pkg::TS_W:0]              elapsed_full;
  logic                                 no_elapsed;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign volt_u   = in_voltage_mv[tfls_pkg::MV_W-1:0];

  // Effective frame limit, clamped to one through the maximum.
  always_comb begin
    if (cfg.frame_limit == '0) begin
      limit = CW'(1);
    end else if (cfg.frame_limit > CW'(tfls_pkg::FRAME_CAP)) begin
      limit = CW'(tfls_pkg::FRAME_CAP);
    end else begin
      limit = cfg.frame_limit;
    end
  end

  assign in_window  = (frame_counter_r < limit);
  assign seq_expect = previous_sequence_r + tfls_pkg::SEQ_W'(1);

  // Field checks in priority order; sequence and time only inside the window.
  always_comb begin
    priority if (in_voltage_mv <= $signed(tfls_pkg::VOLT_W'(0))) begin
      status = tfls_pkg::ST_VOLTAGE;
    end else if (in_current_ma[tfls_pkg::CURR_W-1]) begin
      status = tfls_pkg::ST_CURRENT;
    end else if ((in_temperature_tenths < cfg.temp_min_tenths) ||
                 (in_temperature_tenths > cfg.temp_max_tenths)) begin
      status = tfls_pkg::ST_TEMP;
    end else if (in_gps_fix > tfls_pkg::GPS_W'(1)) begin
      status = tfls_pkg::ST_GPS;
    end else if (in_satellites[tfls_pkg::SATS_W-1]) begin
      status = tfls_pkg::ST_SATS;
    end else if (in_window && (frame_counter_r != '0) &&
                 (tfls_pkg::SEQ_W'(in_sequence_number) != seq_expect)) begin
      status = tfls_pkg::ST_SEQUENCE;
    end else if (in_window && (frame_counter_r != '0) &&
                 (in_timestamp_ms <= previous_time_r)) begin
      status = tfls_pkg::ST_TIMESTAMP;
    end else begin
      status = tfls_pkg::ST_OK;
    end
  end

  // Statistics as they stand once a good frame inside the window is counted.
  always_comb begin
    upd_counter = frame_counter_r;
    upd_first   = first_time_r;
    upd_prev    = previous_time_r;
    upd_seq     = previous_sequence_r;
    upd_min     = min_voltage_r;
    upd_max     = max_voltage_r;
    upd_total   = temperature_total_r;
    upd_low     = low_counter_r;
    if (in_window) begin
      if (frame_counter_r == '0) begin
        upd_first = in_timestamp_ms;
        upd_min   = volt_u;
        upd_max   = volt_u;
      end else begin
        if (volt_u < min_voltage_r) begin
          upd_min = volt_u;
        end
        if (volt_u > max_voltage_r) begin
          upd_max = volt_u;
        end
      end
      upd_prev    = in_timestamp_ms;
      upd_seq     = tfls_pkg::SEQ_W'(in_sequence_number);
      upd_total   = temperature_total_r +
                    {{(tfls_pkg::TOTAL_W-tfls_pkg::TEMP_W){in_temperature_tenths[tfls_pkg::TEMP_W-1]}},
                     in_temperature_tenths};
      upd_counter = frame_counter_r + CW'(1);
      if (volt_u < cfg.low_voltage_mv) begin
        upd_low = low_counter_r + CW'(1);
      end
    end
  end

  // Elapsed time of the log; fewer than two frames or a zero or negative time means no rate.
  assign elapsed_full = {1'b0, upd_prev} - {1'b0, upd_first};
  assign no_elapsed   = (upd_counter < CW'(2)) || elapsed_full[tfls_pkg::TS_W] ||
                        (elapsed_full == '0);

  // Next state and queued job.
  always_comb begin
    frame_counter_nxt     = frame_counter_r;
    first_time_nxt        = first_time_r;
    previous_time_nxt     = previous_time_r;
    previous_sequence_nxt = previous_sequence_r;
    min_voltage_nxt       = min_voltage_r;
    max_voltage_nxt       = max_voltage_r;
    temperature_total_nxt = temperature_total_r;
    low_counter_nxt       = low_counter_r;
    error_seen_nxt        = error_seen_r;
    push                  = 1'b0;
    job                   = '0;
    job.status            = status;

    if (accept) begin
      if (error_seen_r) begin
        // Rest of a failed log is dropped; its last frame starts a new log.
        if (in_last_frame) begin
          error_seen_nxt = 1'b0;
          frame_counter_nxt = '0; first_time_nxt = '0; previous_time_nxt = '0;
          previous_sequence_nxt = '0; min_voltage_nxt = '0; max_voltage_nxt = '0;
          temperature_total_nxt = '0; low_counter_nxt = '0;
        end
      end else if (status != tfls_pkg::ST_OK) begin
        push = 1'b1;
        if (in_last_frame) begin
          frame_counter_nxt = '0; first_time_nxt = '0; previous_time_nxt = '0;
          previous_sequence_nxt = '0; min_voltage_nxt = '0; max_voltage_nxt = '0;
          temperature_total_nxt = '0; low_counter_nxt = '0;
        end else begin
          error_seen_nxt = 1'b1;
        end
      end else if (in_last_frame) begin
        push = 1'b1;
        if (no_elapsed) begin
          job.status = tfls_pkg::ST_NO_ELAPSED;
        end else begin
          job.frames    = upd_counter;
          job.vmin      = upd_min;
          job.vmax      = upd_max;
          job.total     = upd_total;
          job.low_count = upd_low;
          job.elapsed   = elapsed_full[tfls_pkg::TS_W-1:0];
        end
        frame_counter_nxt = '0; first_time_nxt = '0; previous_time_nxt = '0;
        previous_sequence_nxt = '0; min_voltage_nxt = '0; max_voltage_nxt = '0;
        temperature_total_nxt = '0; low_counter_nxt = '0;
      end else begin
        frame_counter_nxt     = upd_counter;
        first_time_nxt        = upd_first;
        previous_time_nxt     = upd_prev;
        previous_sequence_nxt = upd_seq;
        min_voltage_nxt       = upd_min;
        max_voltage_nxt       = upd_max;
        temperature_total_nxt = upd_total;
        low_counter_nxt       = upd_low;
      end
    end
  end

  // Log state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_counter_r     <= '0;
      first_time_r        <= '0;
      previous_time_r     <= '0;
      previous_sequence_r <= '0;
      min_voltage_r       <= '0;
      max_voltage_r       <= '0;
      temperature_total_r <= '0;
      low_counter_r       <= '0;
      error_seen_r        <= 1'b0;
    end else begin
      frame_counter_r     <= frame_counter_nxt;
      first_time_r        <= first_time_nxt;
      previous_time_r     <= previous_time_nxt;
      previous_sequence_r <= previous_sequence_nxt;
      min_voltage_r       <= min_voltage_nxt;
      max_voltage_r       <= max_voltage_nxt;
      temperature_total_r <= temperature_total_nxt;
      low_counter_r       <= low_counter_nxt;
      error_seen_r        <= error_seen_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tfls_back.sv
// Result builder: takes jobs from the queue, finishes summaries with the
// shared serial divider and holds the result beat. Depends on tfls_pkg, tfls_div.
`default_nettype none

module tfls_back (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_empty,
  input  wire tfls_pkg::job_t                      q_job,
  output logic                                     q_pop,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [tfls_pkg::STATUS_W-1:0]            out_status,
  output logic [tfls_pkg::COUNT_W-1:0]             out_frame_count,
  output logic [tfls_pkg::MV_W-1:0]                out_voltage_min_out,
  output logic [tfls_pkg::MV_W-1:0]                out_voltage_max_out,
  output logic signed [tfls_pkg::TEMP_W-1:0]       out_temp_mean,
  output logic [tfls_pkg::COUNT_W-1:0]             out_low_voltage_count,
  output logic [tfls_pkg::RATE_W-1:0]              out_frame_rate_mhz
);

  localparam int PROD_W = tfls_pkg::COUNT_W + 20;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_RATE,
    S_AVG,
    S_SEND
  } state_t;

  state_t                                 state_r;
  tfls_pkg::job_t                         job_r;
  logic                                   out_valid_r;
  logic [tfls_pkg::STATUS_W-1:0]          status_r;
  logic [tfls_pkg::COUNT_W-1:0]           frames_r;
  logic [tfls_pkg::MV_W-1:0]              vmin_r;
  logic [tfls_pkg::MV_W-1:0]              vmax_r;
  logic signed [tfls_pkg::TEMP_W-1:0]     avg_r;
  logic [tfls_pkg::COUNT_W-1:0]           low_r;
  logic [tfls_pkg::RATE_W-1:0]            rate_r;
  logic [tfls_pkg::RATE_W-1:0]            rate_calc_r;
  logic signed [tfls_pkg::TEMP_W-1:0]     avg_calc_r;
  logic [tfls_pkg::DIV_W-1:0]             div_a_r;
  logic [tfls_pkg::TS_W-1:0]              div_b_r;
  logic                                   div_start_r;

  logic                                   slot_free;
  logic                                   div_done;
  logic [tfls_pkg::DIV_W-1:0]             div_q;
  logic [PROD_W-1:0]                      rate_num;
  logic [tfls_pkg::TOTAL_W-1:0]           total_mag;
  logic [tfls_pkg::TEMP_W-1:0]            avg_mag;

  assign slot_free = !out_valid_r || out_ready;

  // Error and empty jobs go straight to the output; summaries start at once.
  assign q_pop = (state_r == S_IDLE) && !q_empty &&
                 ((q_job.status == tfls_pkg::ST_OK) || slot_free);

  // (frames - 1) * 10^6 stays below 2^30 for any count the window allows.
  assign rate_num  = PROD_W'(job_r.frames - tfls_pkg::COUNT_W'(1)) *
                     PROD_W'(tfls_pkg::RATE_SCALE);
  assign total_mag = job_r.total[tfls_pkg::TOTAL_W-1] ? tfls_pkg::TOTAL_W'(-job_r.total)
                                                      : tfls_pkg::TOTAL_W'(job_r.total);
  assign avg_mag   = div_q[tfls_pkg::TEMP_W-1:0];

  tfls_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer and registered result beat. The rate and average are kept
  // apart from the output registers until the summary beat is loaded, so a
  // waiting error beat stays unchanged.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            job_r <= q_job;
            if (q_job.status == tfls_pkg::ST_OK) begin
              state_r <= S_MUL;
            end else begin
              out_valid_r <= 1'b1;
              status_r    <= q_job.status;
              frames_r    <= '0;
              vmin_r      <= '0;
              vmax_r      <= '0;
              avg_r       <= '0;
              low_r       <= '0;
              rate_r      <= '0;
            end
          end
        end
        S_MUL: begin
          div_a_r     <= rate_num[tfls_pkg::DIV_W-1:0];
          div_b_r     <= job_r.elapsed;
          div_start_r <= 1'b1;
          state_r     <= S_RATE;
        end
        S_RATE: begin
          if (div_done) begin
            rate_calc_r <= tfls_pkg::RATE_W'(div_q);
            div_a_r     <= tfls_pkg::DIV_W'(total_mag);
            div_b_r     <= tfls_pkg::TS_W'(job_r.frames);
            div_start_r <= 1'b1;
            state_r     <= S_AVG;
          end
        end
        S_AVG: begin
          if (div_done) begin
            // Truncation toward zero: divide the magnitude, then restore the sign.
            avg_calc_r <= job_r.total[tfls_pkg::TOTAL_W-1] ? $signed(-avg_mag)
                                                           : $signed(avg_mag);
            state_r    <= S_SEND;
          end
        end
        S_SEND: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            status_r    <= job_r.status;
            frames_r    <= job_r.frames;
            vmin_r      <= job_r.vmin;
            vmax_r      <= job_r.vmax;
            avg_r       <= avg_calc_r;
            low_r       <= job_r.low_count;
            rate_r      <= rate_calc_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_frame_count       = frames_r;
  assign out_voltage_min_out   = vmin_r;
  assign out_voltage_max_out   = vmax_r;
  assign out_temp_mean         = avg_r;
  assign out_low_voltage_count = low_r;
  assign out_frame_rate_mhz    = rate_r;

endmodule

`default_nettype wire

>>> hdl/telemetry_frame_log_summarizer.sv
// Top level of the telemetry frame log summarizer: configuration registers,
// frame checker, job queue and result builder. Depends on tfls_pkg and all tfls_ modules.
//
// The block takes one parsed telemetry frame per beat and accepts a new frame
// every cycle while the queue is not full: the checker validates each frame
// and updates the log statistics in the cycle it is accepted. The first failing
// frame of a log, or the last frame of a good log, puts a job into a two-entry queue;
// the result builder takes it when idle (an error job also needs a free output slot).
// An error result is presented on the output in the cycle after its job is
// taken. A summary is presented after S_MUL, S_RATE, S_AVG and S_SEND, the
// shared 30-step serial divider running twice, first for the frame rate and then
// for the average temperature; S_SEND waits for a free output slot. Meanwhile the
// checker keeps accepting frames until the queue holds two further jobs.
`default_nettype none

module telemetry_frame_log_summarizer (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // Configuration port
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [tfls_pkg::CFG_ADDR_W-1:0]       paddr,
  input  wire logic [tfls_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [tfls_pkg::CFG_DATA_W-1:0]            prdata,
  output logic                                       pready,
  // Frame input
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [tfls_pkg::TS_W-1:0]             in_timestamp_ms,
  input  wire logic signed [tfls_pkg::SEQ_W-1:0]     in_sequence_number,
  input  wire logic signed [tfls_pkg::VOLT_W-1:0]    in_voltage_mv,
  input  wire logic signed [tfls_pkg::CURR_W-1:0]    in_current_ma,
  input  wire logic signed [tfls_pkg::TEMP_W-1:0]    in_temperature_tenths,
  input  wire logic [tfls_pkg::GPS_W-1:0]            in_gps_fix,
  input  wire logic signed [tfls_pkg::SATS_W-1:0]    in_satellites,
  input  wire logic                                  in_last_frame,
  // Result output
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [tfls_pkg::STATUS_W-1:0]              out_status,
  output logic [tfls_pkg::COUNT_W-1:0]               out_frame_count,
  output logic [tfls_pkg::MV_W-1:0]                  out_voltage_min_out,
  output logic [tfls_pkg::MV_W-1:0]                  out_voltage_max_out,
  output logic signed [tfls_pkg::TEMP_W-1:0]         out_temp_mean,
  output logic [tfls_pkg::COUNT_W-1:0]               out_low_voltage_count,
  output logic [tfls_pkg::RATE_W-1:0]                out_frame_rate_mhz
);

  tfls_pkg::cfg_t       cfg_r;
  tfls_pkg::reg_index_t reg_sel;
  logic                 cfg_write;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_push;
  logic                 q_pop;
  tfls_pkg::job_t       push_job;
  tfls_pkg::job_t       pop_job;

  assign pready    = 1'b1;
  assign reg_sel   = tfls_pkg::reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_voltage_mv  <= tfls_pkg::MV_W'(tfls_pkg::LOW_VOLTAGE_RST);
      cfg_r.temp_min_tenths <= tfls_pkg::TEMP_W'(tfls_pkg::TEMP_MIN_RST);
      cfg_r.temp_max_tenths <= tfls_pkg::TEMP_W'(tfls_pkg::TEMP_MAX_RST);
      cfg_r.frame_limit     <= tfls_pkg::COUNT_W'(tfls_pkg::FRAME_LIMIT_RST);
    end else if (cfg_write) begin
      unique case (reg_sel)
        tfls_pkg::REG_LOW_VOLTAGE: cfg_r.low_voltage_mv  <= pwdata[tfls_pkg::MV_W-1:0];
        tfls_pkg::REG_TEMP_MIN:    cfg_r.temp_min_tenths <= pwdata[tfls_pkg::TEMP_W-1:0];
        tfls_pkg::REG_TEMP_MAX:    cfg_r.temp_max_tenths <= pwdata[tfls_pkg::TEMP_W-1:0];
        tfls_pkg::REG_FRAME_LIMIT: cfg_r.frame_limit     <= pwdata[tfls_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_sel)
      tfls_pkg::REG_LOW_VOLTAGE: prdata = tfls_pkg::CFG_DATA_W'(cfg_r.low_voltage_mv);
      tfls_pkg::REG_TEMP_MIN:    prdata = tfls_pkg::CFG_DATA_W'(
                                            unsigned'(cfg_r.temp_min_tenths));
      tfls_pkg::REG_TEMP_MAX:    prdata = tfls_pkg::CFG_DATA_W'(
                                            unsigned'(cfg_r.temp_max_tenths));
      tfls_pkg::REG_FRAME_LIMIT: prdata = tfls_pkg::CFG_DATA_W'(cfg_r.frame_limit);
      default:                   prdata = '0;
    endcase
  end

  tfls_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_timestamp_ms       (in_timestamp_ms),
    .in_sequence_number    (in_sequence_number),
    .in_voltage_mv         (in_voltage_mv),
    .in_current_ma         (in_current_ma),
    .in_temperature_tenths (in_temperature_tenths),
    .in_gps_fix            (in_gps_fix),
    .in_satellites         (in_satellites),
    .in_last_frame         (in_last_frame),
    .q_full                (q_full),
    .push                  (q_push),
    .job                   (push_job)
  );

  tfls_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  tfls_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .q_job                 (pop_job),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_frame_count       (out_frame_count),
    .out_voltage_min_out   (out_voltage_min_out),
    .out_voltage_max_out   (out_voltage_max_out),
    .out_temp_mean         (out_temp_mean),
    .out_low_voltage_count (out_low_voltage_count),
    .out_frame_rate_mhz    (out_frame_rate_mhz)
  );

endmodule

`default_nettype wire
